// ===== src/first_fit_heap_allocator_macros.svh =====
// Assertion macros of the allocator top level.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
// Same-cycle implication, checked outside reset.
`define FFHA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked outside reset.
`define FFHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== src/ffha_pkg.sv =====
// Package with shared types and constants of the first-fit heap allocator.
package ffha_pkg;
  localparam int REQ_W = 13;
  localparam int OFF_W = 12;
  localparam int MINCAP_W = 13;
  localparam logic [MINCAP_W-1:0] MIN_CAP_RESET = 13'd24;

  localparam logic [1:0] RES_ZERO  = 2'd0;
  localparam logic [1:0] RES_ALLOC = 2'd1;
  localparam logic [1:0] RES_FAIL  = 2'd2;

  typedef struct packed {
    logic       wr_init;
    logic       ld_in;
    logic       rd_h;
    logic       ld_h;
    logic       rd_nx;
    logic       merge;
    logic       wr_h;
    logic       wr_tail;
    logic       adv;
    logic       res_set;
    logic [1:0] res_code;
    logic       out_ld;
  } cmd_t;

  typedef struct packed {
    logic in_op;
    logic in_free_ok;
    logic op_free;
    logic rd_valid;
    logic rd_free;
    logic hfree;
    logic nx_in;
    logic fits;
    logic split_ok;
    logic out_space;
  } sts_t;
endpackage

// ===== src/first_fit_heap_allocator.sv =====
// Top level of the first-fit heap allocator with split and coalesce.
// Usage: a request beat on the input channel carries operation, request_bytes
// and block_offset; operation 0 allocates, 1 frees. Each request gives one
// result beat on the output channel with status and content_offset.
// The block works on one request at a time; in_stall is high while it is busy.
// An allocate walks the block headers from offset 0 over a header memory with
// one read and one write port. For each block visited it reads the header in
// S_RDH and loads it in S_GOTH; a free block checks the block after it in S_MRG
// and S_MCHK and merges each free neighbour; then S_TEST tests the block. A fit
// that leaves room is split in S_SPLIT, and S_RES loads the result; the length
// of an allocate depends on the number of blocks. A free runs the same steps on
// its own block; a free of an offset below the header size skips to S_RES.
// The next request is taken from the cycle in which the result beat appears.
// The result waits in an output register; a stalled receiver holds the beat
// and the block returns to accept the next request once that register frees.
// Reset clears control state and S_INIT rewrites the first header, so the first
// request is taken in S_IDLE. min_capacity is written through the always-ready
// cfg channel; the user must do so while the block idles, as nothing enforces it.
module first_fit_heap_allocator #(
  parameter int ARENA_BYTES = 4096,
  parameter int HEADER_BYTES = 17
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           operation,
  input  logic [ffha_pkg::REQ_W-1:0]     request_bytes,
  input  logic [ffha_pkg::OFF_W-1:0]     block_offset,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           status,
  output logic [ffha_pkg::OFF_W-1:0]     content_offset,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ffha_pkg::MINCAP_W-1:0]  cfg_data
);
  import ffha_pkg::*;

  `include "first_fit_heap_allocator_macros.svh"

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  ffha_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ffha_datapath #(
    .ARENA_BYTES  (ARENA_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .operation      (operation),
    .request_bytes  (request_bytes),
    .block_offset   (block_offset),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .status         (status),
    .content_offset (content_offset)
  );

  `FFHA_ASSERT_NOW(a_fail_zero, out_valid && status, content_offset == '0, "failed beat has offset")
  `FFHA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted without busy")
  `FFHA_ASSERT_NOW(a_result_from_busy, $rose(out_valid), $past(in_stall), "result while idle")
endmodule

// ===== src/ffha_datapath.sv =====
// Datapath of the allocator: header memory, walk registers and result register.
module ffha_datapath #(
  parameter int ARENA_BYTES = 4096,
  parameter int HEADER_BYTES = 17
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ffha_pkg::cmd_t                 cmd,
  output ffha_pkg::sts_t                 sts,
  input  logic                           operation,
  input  logic [ffha_pkg::REQ_W-1:0]     request_bytes,
  input  logic [ffha_pkg::OFF_W-1:0]     block_offset,
  input  logic                           cfg_valid,
  input  logic [ffha_pkg::MINCAP_W-1:0]  cfg_data,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic                           status,
  output logic [ffha_pkg::OFF_W-1:0]     content_offset
);
  import ffha_pkg::*;

  localparam int AW = $clog2(ARENA_BYTES);
  localparam int CW = ((AW > REQ_W) ? AW : REQ_W) + 2;
  localparam logic [CW-1:0] HB_C = CW'(HEADER_BYTES);
  localparam logic [CW-1:0] AR_C = CW'(ARENA_BYTES);
  localparam logic [AW-1:0] INIT_CAP = AW'(ARENA_BYTES - HEADER_BYTES);

  logic [AW+1:0]         mem [ARENA_BYTES];
  logic [AW+1:0]         rd_data;
  logic [MINCAP_W-1:0]   min_capacity;
  logic [AW-1:0]         h;
  logic [AW-1:0]         hcap;
  logic                  hfree;
  logic                  op_free;
  logic [REQ_W-1:0]      query;
  logic                  res_fail;
  logic [OFF_W-1:0]      res_off;

  logic [CW-1:0]         nx;
  logic [CW-1:0]         free_h;
  logic [CW-1:0]         tail_addr;
  logic [CW-1:0]         merged;
  logic [CW-1:0]         tail_cap;
  logic [CW-1:0]         content_sum;
  logic [REQ_W-1:0]      query_next;
  logic                  we;
  logic [AW-1:0]         wa;
  logic [AW+1:0]         wd;
  logic                  re;
  logic [AW-1:0]         ra;
  logic [AW-1:0]         h_cap_wr;

  assign nx          = CW'(h) + HB_C + CW'(hcap);
  assign free_h      = CW'(block_offset) - HB_C;
  assign tail_addr   = CW'(h) + HB_C + CW'(query);
  assign merged      = CW'(hcap) + HB_C + CW'(rd_data[AW-1:0]);
  assign tail_cap    = CW'(hcap) - CW'(query) - HB_C;
  assign content_sum = CW'(h) + HB_C;
  assign query_next  = (request_bytes < min_capacity) ? min_capacity : request_bytes;

  always_comb begin
    sts.in_op      = operation;
    sts.in_free_ok = (CW'(block_offset) >= HB_C) && (free_h < AR_C);
    sts.op_free    = op_free;
    sts.rd_valid   = rd_data[AW+1];
    sts.rd_free    = rd_data[AW];
    sts.hfree      = hfree;
    sts.nx_in      = nx < AR_C;
    sts.fits       = !op_free && hfree && (CW'(hcap) >= CW'(query));
    sts.split_ok   = (CW'(query) + HB_C + CW'(min_capacity)) <= CW'(hcap);
    sts.out_space  = !out_valid || !out_stall;
  end

  always_comb begin
    h_cap_wr = (sts.fits && sts.split_ok) ? AW'(query) : hcap;
    we = 1'b0;
    wa = h;
    wd = {1'b1, hfree, hcap};
    if (cmd.wr_init) begin
      we = 1'b1;
      wa = '0;
      wd = {1'b1, 1'b1, INIT_CAP};
    end else if (cmd.merge) begin
      we = 1'b1;
      wa = nx[AW-1:0];
      wd = '0;
    end else if (cmd.wr_h) begin
      we = 1'b1;
      wa = h;
      wd = {1'b1, hfree && !sts.fits, h_cap_wr};
    end else if (cmd.wr_tail) begin
      we = 1'b1;
      wa = tail_addr[AW-1:0];
      wd = {1'b1, 1'b1, tail_cap[AW-1:0]};
    end
    re = cmd.rd_h || cmd.rd_nx;
    ra = cmd.rd_nx ? nx[AW-1:0] : h;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_capacity <= MIN_CAP_RESET;
    end else if (cfg_valid) begin
      min_capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      op_free <= operation;
      query   <= query_next;
      h       <= operation ? free_h[AW-1:0] : '0;
    end else if (cmd.adv) begin
      h <= nx[AW-1:0];
    end
    if (cmd.ld_h) begin
      hfree <= op_free || rd_data[AW];
      hcap  <= rd_data[AW-1:0];
    end else if (cmd.merge) begin
      hcap <= merged[AW-1:0];
    end
    if (cmd.res_set) begin
      res_fail <= (cmd.res_code == RES_FAIL);
      res_off  <= (cmd.res_code == RES_ALLOC) ? content_sum[OFF_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      status         <= res_fail;
      content_offset <= res_off;
    end
  end
endmodule

// ===== src/ffha_controller.sv =====
// Controller state machine that sequences the header walk of the allocator.
module ffha_controller (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  ffha_pkg::sts_t sts,
  output ffha_pkg::cmd_t cmd
);
  import ffha_pkg::*;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RDH   = 4'd2;
  localparam logic [3:0] S_GOTH  = 4'd3;
  localparam logic [3:0] S_MRG   = 4'd4;
  localparam logic [3:0] S_MCHK  = 4'd5;
  localparam logic [3:0] S_TEST  = 4'd6;
  localparam logic [3:0] S_SPLIT = 4'd7;
  localparam logic [3:0] S_RES   = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_INIT: begin
        cmd.wr_init = 1'b1;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          if (!sts.in_op || sts.in_free_ok) begin
            state_next = S_RDH;
          end else begin
            cmd.res_set = 1'b1;
            cmd.res_code = RES_ZERO;
            state_next = S_RES;
          end
        end
      end
      S_RDH: begin
        cmd.rd_h = 1'b1;
        state_next = S_GOTH;
      end
      S_GOTH: begin
        if (!sts.rd_valid) begin
          cmd.res_set = 1'b1;
          cmd.res_code = RES_ZERO;
          state_next = S_RES;
        end else begin
          cmd.ld_h = 1'b1;
          state_next = S_MRG;
        end
      end
      S_MRG: begin
        if (sts.hfree && sts.nx_in) begin
          cmd.rd_nx = 1'b1;
          state_next = S_MCHK;
        end else begin
          state_next = S_TEST;
        end
      end
      S_MCHK: begin
        if (sts.rd_valid && sts.rd_free) begin
          cmd.merge = 1'b1;
          state_next = S_MRG;
        end else begin
          state_next = S_TEST;
        end
      end
      S_TEST: begin
        cmd.wr_h = 1'b1;
        cmd.res_set = 1'b1;
        if (sts.op_free) begin
          cmd.res_code = RES_ZERO;
          state_next = S_RES;
        end else if (sts.fits) begin
          cmd.res_code = RES_ALLOC;
          state_next = sts.split_ok ? S_SPLIT : S_RES;
        end else if (sts.nx_in) begin
          cmd.res_set = 1'b0;
          cmd.adv = 1'b1;
          state_next = S_RDH;
        end else begin
          cmd.res_code = RES_FAIL;
          state_next = S_RES;
        end
      end
      S_SPLIT: begin
        cmd.wr_tail = 1'b1;
        state_next = S_RES;
      end
      S_RES: begin
        if (sts.out_space) begin
          cmd.out_ld = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end
endmodule

// ===== verif/first_fit_heap_allocator_test.sv =====
// Self-checking testbench of the first-fit heap allocator with a built-in block-chain predictor.
`timescale 1ns / 1ps
module first_fit_heap_allocator_test;
  import ffha_pkg::*;

  localparam int ARENA = 4096;
  localparam int HDR = 17;
  localparam int STALL_LIMIT = 40000;
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;
  localparam logic ST_DONE = 1'b0;
  localparam logic ST_NOFIT = 1'b1;

  typedef struct packed {
    logic             st;
    logic [OFF_W-1:0] off;
  } reply_t;

  typedef struct {
    logic               op;
    logic [REQ_W-1:0]   req;
    logic [OFF_W-1:0]   off;
    bit                 typed;
    reply_t             want;
  } row_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic operation = OP_ALLOC;
  logic [REQ_W-1:0] request_bytes = '0;
  logic [OFF_W-1:0] block_offset = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic status;
  logic [OFF_W-1:0] content_offset;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [MINCAP_W-1:0] cfg_data = '0;

  first_fit_heap_allocator i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .request_bytes(request_bytes), .block_offset(block_offset),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .content_offset(content_offset),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  int unsigned blk_cap [ARENA];
  bit blk_free [ARENA];
  bit blk_start [ARENA];
  bit hdr_written [ARENA];
  int unsigned min_cap;
  reply_t pending_replies[$];
  int unsigned live_blocks[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void coalesce(int unsigned h);
    int unsigned nx;
    while (blk_free[h]) begin
      nx = h + HDR + blk_cap[h];
      if (nx >= ARENA || !blk_start[nx] || !blk_free[nx]) break;
      blk_cap[h] += HDR + blk_cap[nx];
      blk_start[nx] = 0;
      blk_free[nx] = 0;
      blk_cap[nx] = 0;
    end
  endfunction

  function automatic reply_t heap_step(logic op, logic [REQ_W-1:0] req, logic [OFF_W-1:0] off);
    reply_t r;
    int unsigned want_cap, h, nb;
    r = '0;
    if (op == OP_ALLOC) begin
      want_cap = (req < min_cap) ? min_cap : req;
      h = 0;
      while (h < ARENA && blk_start[h]) begin
        coalesce(h);
        if (blk_free[h] && blk_cap[h] >= want_cap) begin
          if (want_cap + HDR + min_cap <= blk_cap[h]) begin
            nb = h + HDR + want_cap;
            blk_cap[nb] = blk_cap[h] - want_cap - HDR;
            blk_free[nb] = 1;
            blk_start[nb] = 1;
            hdr_written[nb] = 1;
            blk_cap[h] = want_cap;
          end
          blk_free[h] = 0;
          r.off = OFF_W'(h + HDR);
          return r;
        end
        h = h + HDR + blk_cap[h];
      end
      r.st = ST_NOFIT;
    end else if (off >= HDR) begin
      h = off - HDR;
      if (blk_start[h]) begin
        blk_free[h] = 1;
        coalesce(h);
      end
    end
    return r;
  endfunction

  task automatic send_request(logic op, logic [REQ_W-1:0] req, logic [OFF_W-1:0] off,
                              bit typed, reply_t want);
    reply_t got;
    if (op == OP_FREE && off >= HDR && !hdr_written[off - HDR]) off = '0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    request_bytes <= req;
    block_offset <= off;
    do @(posedge clk); while (in_stall);
    got = heap_step(op, req, off);
    pending_replies.push_back(typed ? want : got);
    if (op == OP_ALLOC && got.st == ST_DONE) live_blocks.push_back(got.off);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_min_cap(logic [MINCAP_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    min_cap = v;
  endtask

  task automatic random_requests(int n);
    int pick, idx;
    logic [REQ_W-1:0] req;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        send_request(OP_FREE, '0, OFF_W'($urandom), 0, '0);
      end else if (pick < 48 && live_blocks.size() != 0) begin
        idx = $urandom_range(live_blocks.size() - 1);
        send_request(OP_FREE, '0, OFF_W'(live_blocks[idx]), 0, '0);
        live_blocks.delete(idx);
      end else begin
        req = ($urandom_range(19) == 0) ? REQ_W'($urandom) : REQ_W'($urandom_range(0, 160));
        send_request(OP_ALLOC, req, OFF_W'($urandom), 0, '0);
      end
    end
  endtask

  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    reply_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat: status %0d offset %0d",
                                       status, content_offset);
      end else begin
        exp_r = pending_replies.pop_front();
        if (status !== exp_r.st || content_offset !== exp_r.off) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected status %0d offset %0d, got status %0d offset %0d",
                     exp_r.st, exp_r.off, status, content_offset);
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    row_t plan[$];
    reply_t z;
    z = '0;
    plan = '{
      '{OP_ALLOC, 13'd0,    12'd0,    1, '{ST_DONE, 12'd17}},
      '{OP_ALLOC, 13'd4096, 12'd4095, 1, '{ST_NOFIT, 12'd0}},
      '{OP_ALLOC, 13'd8191, 12'd0,    1, '{ST_NOFIT, 12'd0}},
      '{OP_FREE,  13'd8191, 12'd0,    1, '{ST_DONE, 12'd0}},
      '{OP_FREE,  13'd0,    12'd16,   1, '{ST_DONE, 12'd0}},
      '{OP_FREE,  13'd0,    12'd58,   1, '{ST_DONE, 12'd0}},
      '{OP_FREE,  13'd0,    12'd17,   1, '{ST_DONE, 12'd0}},
      '{OP_FREE,  13'd0,    12'd17,   1, '{ST_DONE, 12'd0}},
      '{OP_ALLOC, 13'd4079, 12'd0,    1, '{ST_DONE, 12'd17}},
      '{OP_ALLOC, 13'd1,    12'd0,    1, '{ST_NOFIT, 12'd0}},
      '{OP_FREE,  13'd0,    12'd17,   1, '{ST_DONE, 12'd0}},
      '{OP_ALLOC, 13'd100,  12'd0,    0, z},
      '{OP_ALLOC, 13'd100,  12'd0,    0, z},
      '{OP_ALLOC, 13'd5,    12'd0,    0, z},
      '{OP_FREE,  13'd0,    12'd134,  1, '{ST_DONE, 12'd0}},
      '{OP_FREE,  13'd0,    12'd17,   1, '{ST_DONE, 12'd0}},
      '{OP_ALLOC, 13'd200,  12'd0,    0, z},
      '{OP_ALLOC, 13'd3800, 12'd0,    0, z},
      '{OP_ALLOC, 13'd3900, 12'd0,    0, z},
      '{OP_FREE,  13'd0,    12'd2730, 0, z}
    };
    for (int a = 0; a < ARENA; a++) begin
      blk_cap[a] = 0;
      blk_free[a] = 0;
      blk_start[a] = 0;
      hdr_written[a] = 0;
    end
    blk_cap[0] = ARENA - HDR;
    blk_free[0] = 1;
    blk_start[0] = 1;
    hdr_written[0] = 1;
    min_cap = MIN_CAP_RESET;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k]) send_request(plan[k].op, plan[k].req, plan[k].off, plan[k].typed,
                                   plan[k].want);
    drain();

    write_min_cap(13'd1);
    random_requests(450);
    drain();

    send_idle_pct = 74;
    write_min_cap(13'd24);
    random_requests(400);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 74;
    hold_off = 400;
    write_min_cap(13'd8);
    random_requests(400);
    drain();

    write_min_cap(13'd8191);
    send_idle_pct = 29;
    recv_stall_pct = 29;
    random_requests(40);
    drain();

    write_min_cap(13'd0);
    random_requests(300);
    drain();

    write_min_cap(13'd4096);
    random_requests(30);
    drain();

    write_min_cap(MINCAP_W'($urandom_range(1, 64)));
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_requests(280);
    drain();

    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_replies.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule
